// ===== sv/dbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared types and constants for the debounce block with chatter guard:
// scan and event items, configuration register codes, event kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package dbc_pkg;

	// Field widths of the configuration registers
	localparam int DebW = 20;
	localparam int LimW = 8;
	localparam int WinW = 16;

	// Configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 20;

	// Scan pins carried by one item, and the event cap per scan
	localparam int PinW      = 8;
	localparam int MaxEvents = 8;

	localparam logic [LimW-1:0] CountSat = 8'd255;

	typedef enum logic [CfgIdxW-1:0] {
		RegCamDebounce  = 3'd0,
		RegBeamDebounce = 3'd1,
		RegCamLimit     = 3'd2,
		RegBeamLimit    = 3'd3,
		RegRateWindow   = 3'd4,
		RegBallLockout  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EvCamEdge  = 2'd0,
		EvBallPass = 2'd1,
		EvChatter  = 2'd2
	} evt_kind_t;

	typedef struct packed {
		logic [PinW-1:0] pin_levels;
		logic [31:0]     stamp_us;
		logic [31:0]     stamp_ms;
		logic            clear_fault;
	} scan_t;

	typedef struct packed {
		logic [2:0]  input_index;
		logic [1:0]  event_kind;
		logic        asserted_edge;
		logic [31:0] event_ms;
		logic        last_event;
	} event_t;

	// Per-pin result of one evaluation
	typedef struct packed {
		logic fire;  // debounced level change this scan
		logic over;  // that change exceeds the rate limit
	} pin_stat_t;

endpackage

`default_nettype wire

// ===== sv/dbc_pin.sv =====
// ----------------------------------------------------------------------------
// dbc_pin
// One pin: candidate tracking, time-based debounce and edge-rate window.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_pin (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        seed,
	input  wire logic                        upd,
	input  wire logic                        asserted,
	input  wire logic [31:0]                 stamp_us,
	input  wire logic [31:0]                 stamp_ms,
	input  wire logic [dbc_pkg::DebW-1:0]    settle_us,
	input  wire logic [dbc_pkg::LimW-1:0]    edge_limit,
	input  wire logic [dbc_pkg::WinW-1:0]    window_ms,
	output dbc_pkg::pin_stat_t               stat
);

	logic                     stable_q;
	logic                     cand_q;
	logic [31:0]              since_q;
	logic [31:0]              wstart_q;
	logic [dbc_pkg::LimW-1:0] cnt_q;

	logic                     cand_chg;
	logic [31:0]              since_eff;
	logic [31:0]              held_us;
	logic                     fire;
	logic                     win_exp;
	logic [dbc_pkg::LimW-1:0] cnt_base;
	logic [dbc_pkg::LimW-1:0] cnt_next;

	always_comb begin
		cand_chg  = asserted != cand_q;
		since_eff = cand_chg ? stamp_us : since_q;
		held_us   = stamp_us - since_eff;
		fire      = (asserted != stable_q) && (held_us >= 32'(settle_us));
		win_exp   = (stamp_ms - wstart_q) >= 32'(window_ms);
		cnt_base  = win_exp ? '0 : cnt_q;
		cnt_next  = (cnt_base == dbc_pkg::CountSat) ? cnt_base : cnt_base + 1'b1;
		stat.fire = fire;
		stat.over = fire && (cnt_next > edge_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			cand_q   <= 1'b0;
			since_q  <= '0;
			wstart_q <= '0;
			cnt_q    <= '0;
		end else if (seed) begin
			stable_q <= asserted;
			cand_q   <= asserted;
			since_q  <= stamp_us;
			wstart_q <= stamp_ms;
			cnt_q    <= '0;
		end else if (upd) begin
			cand_q  <= asserted;
			since_q <= since_eff;
			if (fire) begin
				stable_q <= asserted;
				cnt_q    <= cnt_next;
				if (win_exp) begin
					wstart_q <= stamp_ms;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/dbc_evt_queue.sv =====
// ----------------------------------------------------------------------------
// dbc_evt_queue
// Holds the events of one scan and hands them out one item per cycle while
// evt_ready is high, lowest pin first, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_evt_queue #(
	parameter int NUM_INPUTS = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    load,
	input  wire logic [NUM_INPUTS-1:0]                   load_mask,
	input  wire dbc_pkg::evt_kind_t [NUM_INPUTS-1:0]     load_kind,
	input  wire logic [NUM_INPUTS-1:0]                   load_edge,
	input  wire logic [31:0]                             load_ms,
	output logic                                         busy,
	output logic                                         evt_valid,
	input  wire logic                                    evt_ready,
	output dbc_pkg::event_t                              evt
);

	localparam int IdxW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int CapN = (NUM_INPUTS > dbc_pkg::MaxEvents) ? NUM_INPUTS : dbc_pkg::MaxEvents;
	localparam int CntW = $clog2(CapN + 1);

	logic [NUM_INPUTS-1:0]               mask_q;
	dbc_pkg::evt_kind_t [NUM_INPUTS-1:0] kind_q;
	logic [NUM_INPUTS-1:0]               edge_q;
	logic [31:0]                         ms_q;

	logic [NUM_INPUTS-1:0] kept;
	logic [CntW-1:0]       seen;
	logic [NUM_INPUTS-1:0] head;
	logic [NUM_INPUTS-1:0] rest;
	logic [IdxW-1:0]       idx;

	// Keep only the first events of a scan, up to the cap
	always_comb begin
		kept = '0;
		seen = '0;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			if (load_mask[i] && (seen < CntW'(dbc_pkg::MaxEvents))) begin
				kept[i] = 1'b1;
				seen    = seen + 1'b1;
			end
		end
	end

	always_comb begin
		head = mask_q & (~mask_q + 1'b1);
		rest = mask_q & ~head;
		idx  = '0;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			if (head[i]) begin
				idx = IdxW'(i);
			end
		end
		busy              = |mask_q;
		evt_valid         = busy;
		evt.input_index   = 3'(idx);
		evt.event_kind    = kind_q[idx];
		evt.asserted_edge = edge_q[idx];
		evt.event_ms      = ms_q;
		evt.last_event    = ~|rest;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= kept;
		end else if (evt_valid && evt_ready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= load_kind;
			edge_q <= load_edge;
			ms_q   <= load_ms;
		end
	end

endmodule

`default_nettype wire

// ===== sv/debounce_with_chatter_guard_core.sv =====
// ----------------------------------------------------------------------------
// debounce_with_chatter_guard_core
// Time-based debounce of active-low cam and ball-beam pins with an
// edge-rate chatter fault and a shared ball lockout.
// ----------------------------------------------------------------------------
// Each scan item carries the raw pin levels (zero = asserted) and microsecond
// and millisecond stamps; all time differences wrap at 32 bits. A scan is
// registered, then evaluated for every pin combinationally; its state is
// committed when it leaves the input register. A scan that raises no event
// commits at once, so such scans stream at one item per cycle. A scan that
// raises k events (at most eight are kept, lowest pin first) loads the event
// queue, which drives one result item per cycle onto the output port while
// evt_ready is high; the next scan that raises events waits in the input
// register until the queue has drained. The first scan after reset only
// seeds the pin state and gives no result. Configuration writes are accepted
// every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module debounce_with_chatter_guard_core #(
	parameter int NUM_INPUTS = 8,
	parameter int NUM_BEAMS  = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            scan_valid,
	output logic                                 scan_ready,
	input  wire dbc_pkg::scan_t                  scan,
	output logic                                 evt_valid,
	input  wire logic                            evt_ready,
	output dbc_pkg::event_t                      evt,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [dbc_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [dbc_pkg::CfgDataW-1:0]    cfg_data
);

	localparam int FirstBeam = NUM_INPUTS - NUM_BEAMS;

	// Configuration registers
	logic [dbc_pkg::DebW-1:0] cam_deb_q;
	logic [dbc_pkg::DebW-1:0] beam_deb_q;
	logic [dbc_pkg::LimW-1:0] cam_lim_q;
	logic [dbc_pkg::LimW-1:0] beam_lim_q;
	logic [dbc_pkg::WinW-1:0] window_q;
	logic [dbc_pkg::WinW-1:0] lockout_q;

	// Input register
	logic            valid_s1;
	dbc_pkg::scan_t  scan_s1;

	// Shared state
	logic        seeded_q;
	logic        chatter_q;
	logic [31:0] last_ball_q;

	logic                                commit;
	logic [NUM_INPUTS-1:0]               asrt;
	dbc_pkg::pin_stat_t [NUM_INPUTS-1:0] stat;
	logic [NUM_INPUTS-1:0]               evt_mask;
	logic [NUM_INPUTS-1:0]               fault_v;
	dbc_pkg::evt_kind_t [NUM_INPUTS-1:0] kind_v;
	logic [NUM_INPUTS-1:0]               edge_v;
	logic                                lat;
	logic                                ball_done;
	logic                                ball_old_ok;
	logic                                ball_zero;
	logic                                any_evt;
	logic                                q_busy;
	logic                                q_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_deb_q  <= 20'd5000;
			beam_deb_q <= 20'd1000;
			cam_lim_q  <= 8'd20;
			beam_lim_q <= 8'd40;
			window_q   <= 16'd1000;
			lockout_q  <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dbc_pkg::RegCamDebounce:  cam_deb_q  <= cfg_data;
				dbc_pkg::RegBeamDebounce: beam_deb_q <= cfg_data;
				dbc_pkg::RegCamLimit:     cam_lim_q  <= cfg_data[dbc_pkg::LimW-1:0];
				dbc_pkg::RegBeamLimit:    beam_lim_q <= cfg_data[dbc_pkg::LimW-1:0];
				dbc_pkg::RegRateWindow:   window_q   <= cfg_data[dbc_pkg::WinW-1:0];
				dbc_pkg::RegBallLockout:  lockout_q  <= cfg_data[dbc_pkg::WinW-1:0];
				default: ;
			endcase
		end
	end

	// Hold a scan in the input register until it commits. A scan with events
	// needs an empty queue; one without events always commits.
	assign commit     = valid_s1 && (!any_evt || !q_busy);
	assign scan_ready = !valid_s1 || commit;
	assign q_load     = commit && any_evt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_ready) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid && scan_ready) begin
			scan_s1 <= scan;
		end
	end

	// Per-pin debounce and rate window; pins past the scan width read asserted
	for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_pin
		localparam bit IsBeam = (g >= FirstBeam);
		if (g < dbc_pkg::PinW) begin : g_lvl
			assign asrt[g] = ~scan_s1.pin_levels[g];
		end else begin : g_tie
			assign asrt[g] = 1'b1;
		end
		dbc_pin u_pin (
			.clk         (clk),
			.arst_n      (arst_n),
			.seed        (commit && !seeded_q),
			.upd         (commit && seeded_q),
			.asserted    (asrt[g]),
			.stamp_us    (scan_s1.stamp_us),
			.stamp_ms    (scan_s1.stamp_ms),
			.settle_us   (IsBeam ? beam_deb_q : cam_deb_q),
			.edge_limit  (IsBeam ? beam_lim_q : cam_lim_q),
			.window_ms   (window_q),
			.stat        (stat[g])
		);
	end

	// Walk pins lowest first: the first over-limit edge latches the fault,
	// later ones drop silently; a ball inside the lockout is dropped, and a
	// second beam in the same scan only passes with a zero lockout.
	always_comb begin
		ball_old_ok = (scan_s1.stamp_ms - last_ball_q) >= 32'(lockout_q);
		ball_zero   = lockout_q == '0;
		lat         = chatter_q && !scan_s1.clear_fault;
		ball_done   = 1'b0;
		evt_mask    = '0;
		fault_v     = '0;
		edge_v      = '0;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			kind_v[i] = dbc_pkg::EvCamEdge;
			if (seeded_q && stat[i].fire) begin
				if (stat[i].over) begin
					if (!lat) begin
						lat         = 1'b1;
						evt_mask[i] = 1'b1;
						fault_v[i]  = 1'b1;
						kind_v[i]   = dbc_pkg::EvChatter;
						edge_v[i]   = asrt[i];
					end
				end else if (i >= FirstBeam) begin
					if (asrt[i] && (ball_zero || (ball_old_ok && !ball_done))) begin
						ball_done   = 1'b1;
						evt_mask[i] = 1'b1;
						kind_v[i]   = dbc_pkg::EvBallPass;
						edge_v[i]   = 1'b1;
					end
				end else begin
					evt_mask[i] = 1'b1;
					edge_v[i]   = asrt[i];
				end
			end
		end
		any_evt = |evt_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q    <= 1'b0;
			chatter_q   <= 1'b0;
			last_ball_q <= '0;
		end else if (commit) begin
			seeded_q  <= 1'b1;
			chatter_q <= lat;
			if (ball_done) begin
				last_ball_q <= scan_s1.stamp_ms;
			end
		end
	end

	dbc_evt_queue #(
		.NUM_INPUTS (NUM_INPUTS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (q_load),
		.load_mask (evt_mask),
		.load_kind (kind_v),
		.load_edge (edge_v),
		.load_ms   (scan_s1.stamp_ms),
		.busy      (q_busy),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

	// Never overwrite events that are still being handed out
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_load |-> !q_busy)
		else $error("event queue loaded while busy");

	// The seeding scan raises nothing
	a_seed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !seeded_q) |-> !any_evt)
		else $error("events raised by seeding scan");

	// At most one chatter fault per scan
	a_one_fault: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(fault_v) <= 1)
		else $error("more than one chatter fault in a scan");

	// The fault latch only drops on a committed clear
	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(chatter_q && !(commit && scan_s1.clear_fault)) |=> chatter_q)
		else $error("chatter fault dropped without clear");

	// A reported ball moves the lockout reference to the scan stamp
	a_ball_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && ball_done) |=> (last_ball_q == $past(scan_s1.stamp_ms)))
		else $error("ball lockout reference not updated");

endmodule

`default_nettype wire

// ===== tb/tb_debounce_with_chatter_guard_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debounce_with_chatter_guard_core
// Self-checking bench for the pin debounce core with chatter guard: a queued
// scan driver, an event monitor with random back-pressure, and a cycle-free
// scan-level predictor that every received event is compared against.
// ----------------------------------------------------------------------------

module tb_debounce_with_chatter_guard_core;

	localparam int NumPins       = dbc_pkg::PinW;
	localparam int NumBeams      = 2;
	localparam int DrainCycles   = 24;
	localparam int HoldOffCycles = 300;
	localparam int ReportLimit   = 10;

	// Clock and reset; every block input starts at a known value
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                         scan_valid = 1'b0;
	logic                         scan_ready;
	dbc_pkg::scan_t               scan       = '0;
	logic                         evt_valid;
	logic                         evt_ready  = 1'b0;
	dbc_pkg::event_t              evt;
	logic                         cfg_valid  = 1'b0;
	logic                         cfg_ready;
	logic [dbc_pkg::CfgIdxW-1:0]  cfg_index  = '0;
	logic [dbc_pkg::CfgDataW-1:0] cfg_data   = '0;

	// Traffic shaping: steady turns idling off, hold_off parks the receiver
	logic steady   = 1'b0;
	logic hold_off = 1'b0;

	dbc_pkg::scan_t  scan_pending[$];
	dbc_pkg::event_t predicted_events[$];
	int     scan_gap       = 0;
	int     evt_stall      = 0;
	int     mismatches     = 0;
	int     events_checked = 0;

	// Predictor copy of the configuration registers, at reset values
	logic [dbc_pkg::DebW-1:0] cam_debounce  = 20'd5000;
	logic [dbc_pkg::DebW-1:0] beam_debounce = 20'd1000;
	logic [dbc_pkg::LimW-1:0] cam_limit     = 8'd20;
	logic [dbc_pkg::LimW-1:0] beam_limit    = 8'd40;
	logic [dbc_pkg::WinW-1:0] rate_window   = 16'd1000;
	logic [dbc_pkg::WinW-1:0] ball_lockout  = 16'd100;

	// Predictor copy of the pin state; bit types start at zero like reset
	bit                     seeded;
	bit                     stable_level    [NumPins];
	bit                     candidate_level [NumPins];
	bit [31:0]              candidate_since [NumPins];
	bit [31:0]              window_start    [NumPins];
	bit [dbc_pkg::LimW-1:0] window_count    [NumPins];
	bit [31:0]              ball_ref_ms;
	bit                     chatter_latched;

	// Stimulus generator timeline; starts near the top to cross the wrap
	logic [31:0]              gen_us     = 32'hFFFF_E000;
	logic [31:0]              gen_ms     = 32'hFFFF_FF00;
	logic [dbc_pkg::PinW-1:0] gen_levels = 8'hFF;

	debounce_with_chatter_guard_core #(
		.NUM_INPUTS(NumPins),
		.NUM_BEAMS (NumBeams)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_valid(scan_valid),
		.scan_ready(scan_ready),
		.scan      (scan),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
	end

	// Idle length: mostly none or short, now and then a long one
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic dbc_pkg::event_t pin_event(input int pin,
			input dbc_pkg::evt_kind_t kind, input logic edge_dir, input logic [31:0] ms);
		dbc_pkg::event_t ev;
		ev.input_index   = pin[2:0];
		ev.event_kind    = kind;
		ev.asserted_edge = edge_dir;
		ev.event_ms      = ms;
		ev.last_event    = 1'b0;
		return ev;
	endfunction

	// Advance the pin state by one scan and queue the events it raises,
	// lowest pin first, with the last one of the scan marked.
	task automatic debounce_scan(input dbc_pkg::scan_t s);
		dbc_pkg::event_t          found[$];
		logic                     now_asserted;
		logic                     is_beam;
		logic [31:0]              deb_us;
		logic [dbc_pkg::LimW-1:0] limit;
		logic [31:0]              held_us;
		logic [31:0]              window_age;
		logic [31:0]              since_ball;
		if (s.clear_fault)
			chatter_latched = 1'b0;
		// First scan after reset only seeds every pin
		if (!seeded) begin
			for (int i = 0; i < NumPins; i++) begin
				stable_level[i]    = ~s.pin_levels[i];
				candidate_level[i] = ~s.pin_levels[i];
				candidate_since[i] = s.stamp_us;
				window_start[i]    = s.stamp_ms;
				window_count[i]    = '0;
			end
			seeded = 1'b1;
			return;
		end
		for (int i = 0; i < NumPins; i++) begin
			now_asserted = ~s.pin_levels[i];
			is_beam      = (i >= NumPins - NumBeams);
			deb_us       = is_beam ? {12'd0, beam_debounce} : {12'd0, cam_debounce};
			limit        = is_beam ? beam_limit : cam_limit;
			if (now_asserted != candidate_level[i]) begin
				candidate_level[i] = now_asserted;
				candidate_since[i] = s.stamp_us;
			end
			held_us = s.stamp_us - candidate_since[i];
			if (now_asserted == stable_level[i] || held_us < deb_us)
				continue;
			stable_level[i] = now_asserted;
			// Restart the rate window once it has run out (a zero window
			// restarts on every edge)
			window_age = s.stamp_ms - window_start[i];
			if (window_age >= {16'd0, rate_window}) begin
				window_start[i] = s.stamp_ms;
				window_count[i] = '0;
			end
			if (window_count[i] != dbc_pkg::CountSat)
				window_count[i]++;
			// Over the limit: latch the fault once, drop the pin's event
			if (window_count[i] > limit) begin
				if (!chatter_latched) begin
					chatter_latched = 1'b1;
					if (found.size() < dbc_pkg::MaxEvents)
						found.push_back(pin_event(i, dbc_pkg::EvChatter, now_asserted,
							s.stamp_ms));
				end
				continue;
			end
			if (is_beam) begin
				// Ball only on assertion, outside the lockout shared by all beams
				since_ball = s.stamp_ms - ball_ref_ms;
				if (now_asserted && since_ball >= {16'd0, ball_lockout}) begin
					ball_ref_ms = s.stamp_ms;
					if (found.size() < dbc_pkg::MaxEvents)
						found.push_back(pin_event(i, dbc_pkg::EvBallPass, 1'b1, s.stamp_ms));
				end
			end else if (found.size() < dbc_pkg::MaxEvents) begin
				found.push_back(pin_event(i, dbc_pkg::EvCamEdge, now_asserted, s.stamp_ms));
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].last_event = 1'b1;
		foreach (found[k])
			predicted_events.push_back(found[k]);
	endtask

	// Scan driver: present the next pending item, hold it until accepted,
	// then idle for a random gap. Accepted items go straight to the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_valid <= 1'b0;
			scan_gap = 0;
		end else begin
			if (scan_valid && scan_ready)
				debounce_scan(scan);
			if (scan_valid && !scan_ready) begin
				// hold the offered item
			end else if (scan_gap > 0) begin
				scan_gap--;
				scan_valid <= 1'b0;
			end else if (scan_pending.size() > 0) begin
				scan       <= scan_pending.pop_front();
				scan_valid <= 1'b1;
				scan_gap = steady ? 0 : idle_cycles();
			end else begin
				scan_valid <= 1'b0;
			end
		end
	end

	// Event monitor: check each accepted event against the oldest prediction,
	// then decide the next ready with random stalls or the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ready <= 1'b0;
			evt_stall = 0;
		end else begin
			if (evt_valid && evt_ready) begin
				events_checked++;
				if (predicted_events.size() == 0) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display("ERROR: unexpected event idx=%0d kind=%0d edge=%0d ms=%h last=%0d",
							evt.input_index, evt.event_kind, evt.asserted_edge,
							evt.event_ms, evt.last_event);
				end else begin
					automatic dbc_pkg::event_t want = predicted_events.pop_front();
					if (evt.input_index !== want.input_index ||
							evt.event_kind !== want.event_kind ||
							evt.asserted_edge !== want.asserted_edge ||
							evt.event_ms !== want.event_ms ||
							evt.last_event !== want.last_event) begin
						mismatches++;
						if (mismatches <= ReportLimit)
							$display("ERROR: expected %0d/%0d/%0d/%h/%0d got %0d/%0d/%0d/%h/%0d",
								want.input_index, want.event_kind, want.asserted_edge,
								want.event_ms, want.last_event,
								evt.input_index, evt.event_kind, evt.asserted_edge,
								evt.event_ms, evt.last_event);
					end
				end
			end
			if (hold_off) begin
				evt_ready <= 1'b0;
			end else if (evt_stall > 0) begin
				evt_stall--;
				evt_ready <= 1'b0;
			end else begin
				evt_ready <= 1'b1;
				evt_stall = steady ? 0 : idle_cycles();
			end
		end
	end

	// Long receiver hold-off once traffic is flowing, so the event queue
	// fills and the scan input backs up while the driver keeps offering
	initial begin
		wait (events_checked >= 30);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HoldOffCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Write one register and track it in the predictor once accepted
	task automatic write_reg(input dbc_pkg::cfg_reg_t idx,
			input logic [dbc_pkg::CfgDataW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			dbc_pkg::RegCamDebounce:  cam_debounce  = value[dbc_pkg::DebW-1:0];
			dbc_pkg::RegBeamDebounce: beam_debounce = value[dbc_pkg::DebW-1:0];
			dbc_pkg::RegCamLimit:     cam_limit     = value[dbc_pkg::LimW-1:0];
			dbc_pkg::RegBeamLimit:    beam_limit    = value[dbc_pkg::LimW-1:0];
			dbc_pkg::RegRateWindow:   rate_window   = value[dbc_pkg::WinW-1:0];
			dbc_pkg::RegBallLockout:  ball_lockout  = value[dbc_pkg::WinW-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int cam_deb, input int beam_deb, input int cam_lim,
			input int beam_lim, input int win, input int lockout);
		write_reg(dbc_pkg::RegCamDebounce, cam_deb[dbc_pkg::CfgDataW-1:0]);
		write_reg(dbc_pkg::RegBeamDebounce, beam_deb[dbc_pkg::CfgDataW-1:0]);
		write_reg(dbc_pkg::RegCamLimit, cam_lim[dbc_pkg::CfgDataW-1:0]);
		write_reg(dbc_pkg::RegBeamLimit, beam_lim[dbc_pkg::CfgDataW-1:0]);
		write_reg(dbc_pkg::RegRateWindow, win[dbc_pkg::CfgDataW-1:0]);
		write_reg(dbc_pkg::RegBallLockout, lockout[dbc_pkg::CfgDataW-1:0]);
	endtask

	// Advance the generator timeline and queue one scan
	task automatic queue_scan(input logic [dbc_pkg::PinW-1:0] levels, input logic [31:0] dus,
			input logic [31:0] dms, input logic clr);
		dbc_pkg::scan_t s;
		gen_us     = gen_us + dus;
		gen_ms     = gen_ms + dms;
		gen_levels = levels;
		s.pin_levels  = levels;
		s.stamp_us    = gen_us;
		s.stamp_ms    = gen_ms;
		s.clear_fault = clr;
		scan_pending.push_back(s);
	endtask

	// Random scans shaped around the debounce times: most scans hold or flip
	// a few pins and step time short of, right at, or past the debounce time
	task automatic random_scans(input int count);
		logic [dbc_pkg::PinW-1:0] flip;
		logic [31:0]              dus;
		logic [31:0]              dms;
		int                       deb;
		int                       pick;
		@(negedge clk);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				flip = '0;
			else if (pick < 60)
				flip = 8'd1 << $urandom_range(0, NumPins - 1);
			else if (pick < 75)
				flip = dbc_pkg::PinW'($urandom & $urandom);
			else if (pick < 85)
				flip = 8'hFF;
			else
				flip = dbc_pkg::PinW'($urandom);
			deb  = $urandom_range(0, 1) ? int'(beam_debounce) : int'(cam_debounce);
			pick = $urandom_range(0, 99);
			if (pick < 35)
				dus = $urandom_range(0, deb / 2);
			else if (pick < 65)
				dus = (deb < 2) ? $urandom_range(0, 2) : deb - 2 + $urandom_range(0, 4);
			else if (pick < 95)
				dus = deb + $urandom_range(0, deb + 100);
			else
				dus = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 85)
				dms = dus / 1000 + $urandom_range(0, 3);
			else if (pick < 95)
				dms = rate_window + $urandom_range(0, 2) - 1;
			else
				dms = $urandom;
			queue_scan(gen_levels ^ flip, dus, dms, $urandom_range(0, 9) == 0);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (scan_pending.size() != 0 || scan_valid || predicted_events.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		wait (arst_n);
		@(negedge clk);

		// Directed part at reset configuration: seed, debounce just short of
		// and at the threshold, cam edges both ways, beam release silent,
		// ball lockout hit, fault clear, all-asserted and all-released scans,
		// and both timestamps crossing the 32-bit wrap.
		queue_scan(8'hFF, 0, 0, 1'b1);
		queue_scan(8'h00, 10, 0, 1'b0);
		queue_scan(8'h00, 999, 1, 1'b0);
		queue_scan(8'h00, 1, 0, 1'b0);
		queue_scan(8'h00, 4000, 5, 1'b0);
		queue_scan(8'hFF, 2000, 200, 1'b0);
		queue_scan(8'hFF, 5000, 1, 1'b0);
		queue_scan(8'h3F, 1000, 50, 1'b0);
		queue_scan(8'h3F, 1000, 60, 1'b0);
		queue_scan(8'h55, 300, 10, 1'b0);
		queue_scan(8'h55, 5000, 10, 1'b0);
		queue_scan(8'hAA, 6000, 10, 1'b1);
		queue_scan(8'hAA, 6000, 20, 1'b0);
		queue_scan(8'hAA, 10, 100, 1'b0);
		wait_drained();

		// No debounce, tight limits and a short window: dense edges, faults
		// and up to eight events per scan; the hold-off lands here
		write_all(0, 0, 3, 2, 50, 0);
		random_scans(60);
		wait_drained();

		// Top of the limit, window and lockout ranges, long debounce times, no idling
		steady <= 1'b1;
		write_all(1000000, 1000000, 255, 255, 65535, 65535);
		random_scans(40);
		wait_drained();
		steady <= 1'b0;

		// Zero limits and a zero window: every edge trips the guard
		write_all($urandom_range(1, 50), $urandom_range(1, 50), 0, 0, 0,
			$urandom_range(1, 20));
		random_scans(50);
		wait_drained();

		// Mid-range random settings
		write_all($urandom_range(0, 20000), $urandom_range(0, 5000), $urandom_range(1, 8),
			$urandom_range(1, 12), $urandom_range(1, 500), $urandom_range(0, 200));
		random_scans(60);
		wait_drained();

		if (mismatches == 0 && predicted_events.size() == 0) begin
			$display("debounce_with_chatter_guard_core test passed");
		end else begin
			$display("debounce_with_chatter_guard_core test failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("debounce_with_chatter_guard_core test failed");
		$finish;
	end

endmodule

// ===== debounce_with_chatter_guard_core.f =====
sv/dbc_pkg.sv
sv/dbc_pin.sv
sv/dbc_evt_queue.sv
sv/debounce_with_chatter_guard_core.sv
tb/tb_debounce_with_chatter_guard_core.sv
